>>> design/oets_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odd-even transposition sorter package
// Element type and the control word that the sequencer hands to every cell.
// ----------------------------------------------------------------------------
package oets_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] elem_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_SORT,
    OP_EMIT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     lo_en;
    logic     hi_en;
  } cell_ctrl_t;

endpackage

>>> design/oets_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorter input channel
// Valid/ready channel carrying one list element and its end-of-list mark.
// ----------------------------------------------------------------------------
interface oets_in_if
  import oets_pkg::*;
();
  logic  valid;
  logic  ready;
  elem_t value;
  logic  is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink (input valid, input value, input is_last, output ready);
endinterface

>>> design/oets_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorter output channel
// Valid/ready channel carrying one sorted element with its run flags.
// ----------------------------------------------------------------------------
interface oets_out_if
  import oets_pkg::*;
();
  logic  valid;
  logic  ready;
  elem_t sorted_value;
  logic  last_out;
  logic  overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink (input valid, input sorted_value, input last_out, input overflow,
                output ready);
endinterface

>>> design/oets_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorter cell
// Holds one element; shifts it along the row or compare-swaps with a neighbour.
// ----------------------------------------------------------------------------
module oets_cell
  import oets_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  elem_t      left_value,
  input  elem_t      right_value,
  output elem_t      value
);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: value <= left_value;
      OP_EMIT: value <= right_value;
      OP_SORT: begin
        if (ctrl.lo_en && (value > right_value)) begin
          value <= right_value;
        end else if (ctrl.hi_en && (left_value > value)) begin
          value <= left_value;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> design/odd_even_transposition_sort.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odd-even transposition sort
// A list is loaded into the cell row, sorted by phases (one phase per cycle
// across the whole cell row) and then emitted element by element; the next
// list is taken once the last result has been transferred. Reset empties the
// row and clears the overflow flag.
// ----------------------------------------------------------------------------
module odd_even_transposition_sort
  import oets_pkg::*;
#(
  parameter int unsigned SLOTS = 16
) (
  input  logic         clk,
  input  logic         rst,
  oets_in_if.sink      items,
  oets_out_if.source   results
);

  localparam int unsigned CW = $clog2(SLOTS + 1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } state_t;

  state_t         state;
  logic [CW-1:0]  count;
  logic [CW-1:0]  phase;
  logic           dropped;

  cell_op_t       op;
  elem_t          cell_value [SLOTS];
  cell_ctrl_t     cell_ctrl  [SLOTS];
  logic           pair_en    [SLOTS];

  logic item_xfer;
  logic result_xfer;

  assign items.ready   = (state == ST_LOAD);
  assign item_xfer     = items.valid && items.ready;
  assign result_xfer   = results.valid && results.ready;

  assign results.valid        = (state == ST_EMIT);
  assign results.sorted_value = cell_value[0];
  assign results.last_out     = (count == CW'(1));
  assign results.overflow     = dropped;

  always_comb begin
    op = OP_HOLD;
    unique case (state)
      ST_LOAD: if (item_xfer && (count < CW'(SLOTS))) op = OP_LOAD;
      ST_SORT: op = OP_SORT;
      ST_EMIT: if (result_xfer) op = OP_EMIT;
      default: op = OP_HOLD;
    endcase
  end

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    localparam logic [CW-1:0] NEXT_IDX = CW'(i + 1);
    localparam logic          PARITY   = 1'(i % 2);

    assign pair_en[i] = (PARITY == phase[0]) && (NEXT_IDX < count);

    assign cell_ctrl[i].op    = op;
    assign cell_ctrl[i].lo_en = pair_en[i];
    if (i == 0) begin : g_first
      assign cell_ctrl[i].hi_en = 1'b0;
    end else begin : g_rest
      assign cell_ctrl[i].hi_en = pair_en[i-1];
    end

    oets_cell u_cell (
      .clk         (clk),
      .ctrl        (cell_ctrl[i]),
      .left_value  ((i == 0) ? items.value : cell_value[(i == 0) ? 0 : i-1]),
      .right_value ((i == SLOTS-1) ? cell_value[i] : cell_value[(i == SLOTS-1) ? i : i+1]),
      .value       (cell_value[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_LOAD;
      count   <= '0;
      phase   <= '0;
      dropped <= 1'b0;
    end else begin
      unique case (state)
        ST_LOAD: begin
          if (item_xfer) begin
            if (count < CW'(SLOTS)) begin
              count <= count + CW'(1);
            end else begin
              dropped <= 1'b1;
            end
            if (items.is_last) begin
              state <= ST_SORT;
              phase <= '0;
            end
          end
        end
        ST_SORT: begin
          phase <= phase + CW'(1);
          if (phase + CW'(1) >= count) begin
            state <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (result_xfer) begin
            count <= count - CW'(1);
            if (count == CW'(1)) begin
              state   <= ST_LOAD;
              dropped <= 1'b0;
            end
          end
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

endmodule

>>> tb/tb_odd_even_transposition_sort.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odd-even transposition sorter testbench
// Sends lists of signed elements, some longer than the row so that elements
// are dropped, under three back-pressure regimes. A scoreboard sorts every
// accepted list in its own copy and checks each transferred result, field by
// field, against the oldest expected element.
// ----------------------------------------------------------------------------
module tb_odd_even_transposition_sort;
  import oets_pkg::*;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned RANDOM_ITEMS = 300;
  localparam int unsigned DRAIN_CYCLES = 4 * SLOTS;
  localparam time RUN_LIMIT = 4_000_000;

  typedef struct {
    elem_t value;
    logic  last_out;
    logic  overflow;
  } sorted_entry_t;

  class sort_scoreboard;
    elem_t         list_q[$];
    bit            list_dropped;
    sorted_entry_t sorted_q[$];
    int            errors;
    int            results_seen;

    function new();
      list_dropped = 1'b0;
      errors = 0;
      results_seen = 0;
    endfunction

    function bit transposition_phase(int unsigned first);
      elem_t tmp;
      bit    swapped;
      swapped = 1'b0;
      for (int unsigned i = first; i + 1 < list_q.size(); i += 2) begin
        if (list_q[i] > list_q[i+1]) begin
          tmp = list_q[i];
          list_q[i] = list_q[i+1];
          list_q[i+1] = tmp;
          swapped = 1'b1;
        end
      end
      return swapped;
    endfunction

    function void note_item(elem_t value, logic is_last);
      bit            swapped;
      sorted_entry_t entry;
      if (list_q.size() < SLOTS) begin
        list_q.push_back(value);
      end else begin
        list_dropped = 1'b1;
      end
      if (is_last) begin
        do begin
          swapped = transposition_phase(0);
          if (transposition_phase(1)) swapped = 1'b1;
        end while (swapped);
        for (int k = 0; k < list_q.size(); k++) begin
          entry.value = list_q[k];
          entry.last_out = (k == list_q.size() - 1);
          entry.overflow = list_dropped;
          sorted_q.push_back(entry);
        end
        list_q.delete();
        list_dropped = 1'b0;
      end
    endfunction

    task report(input string msg);
      $display("%0t MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(elem_t value, logic last_out, logic overflow);
      sorted_entry_t entry;
      results_seen++;
      if (sorted_q.size() == 0) begin
        report($sformatf("unexpected result value %0d", value));
      end else begin
        entry = sorted_q.pop_front();
        if (value !== entry.value)
          report($sformatf("sorted_value %0d, expected %0d", value, entry.value));
        if (last_out !== entry.last_out)
          report($sformatf("last_out %b, expected %b", last_out, entry.last_out));
        if (overflow !== entry.overflow)
          report($sformatf("overflow %b, expected %b", overflow, entry.overflow));
      end
    endtask

    function int unsigned outstanding();
      return sorted_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;

  oets_in_if  items_if ();
  oets_out_if results_if ();

  odd_even_transposition_sort #(
    .SLOTS(SLOTS)
  ) DUT (
    .clk    (clk),
    .rst    (rst),
    .items  (items_if),
    .results(results_if)
  );

  sort_scoreboard sb;
  int unsigned    send_idle_pct;
  int unsigned    recv_idle_pct;
  int unsigned    items_sent;
  int unsigned    lists_sent;
  int unsigned    overflow_lists;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    results_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (items_if.valid && items_if.ready)
        sb.note_item(items_if.value, items_if.is_last);
      if (results_if.valid && results_if.ready)
        sb.check_result(results_if.sorted_value, results_if.last_out, results_if.overflow);
    end
  end

  // Entered and left just after a falling edge.
  task send_item(input elem_t value, input logic is_last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      items_if.valid <= 1'b0;
      @(negedge clk);
    end
    items_if.valid   <= 1'b1;
    items_if.value   <= value;
    items_if.is_last <= is_last;
    do @(posedge clk); while (!items_if.ready);
    items_sent++;
    @(negedge clk);
  endtask

  function elem_t random_value();
    elem_t v;
    case ($urandom_range(0, 3))
      0, 1: v = $urandom;
      2: v = $signed($urandom_range(0, 15)) - 8;
      default: begin
        case ($urandom_range(0, 3))
          0: v = {1'b1, {(VALUE_W-1){1'b0}}};
          1: v = {1'b0, {(VALUE_W-1){1'b1}}};
          2: v = '0;
          default: v = '1;
        endcase
      end
    endcase
    return v;
  endfunction

  task send_random_list();
    int unsigned len;
    if ($urandom_range(0, 99) < 12) begin
      len = $urandom_range(SLOTS + 1, SLOTS + 4);
    end else if ($urandom_range(0, 2) == 0) begin
      len = $urandom_range(1, 4);
    end else begin
      len = $urandom_range(1, SLOTS);
    end
    if (len > SLOTS) overflow_lists++;
    lists_sent++;
    for (int unsigned k = 0; k < len; k++)
      send_item(random_value(), k == len - 1);
  endtask

  initial begin
    #(RUN_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    items_if.valid = 1'b0;
    items_if.value = '0;
    items_if.is_last = 1'b0;
    results_if.ready = 1'b0;
    send_idle_pct = 8;
    recv_idle_pct = 69;
    items_sent = 0;
    lists_sent = 0;
    overflow_lists = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // A single element, the field extremes, then a descending list with
    // duplicates that is one element too long, so the marked element is dropped.
    send_item({1'b1, {(VALUE_W-1){1'b0}}}, 1'b1);
    send_item({1'b0, {(VALUE_W-1){1'b1}}}, 1'b0);
    send_item({1'b1, {(VALUE_W-1){1'b0}}}, 1'b0);
    send_item('0, 1'b0);
    send_item('1, 1'b0);
    send_item(elem_t'(1), 1'b1);
    for (int k = 0; k <= SLOTS; k++)
      send_item(elem_t'(8 - (k >>> 1)), k == SLOTS);
    lists_sent += 3;
    overflow_lists++;

    while (items_sent < 23 + RANDOM_ITEMS) begin
      if (items_sent >= 23 + 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (items_sent >= 23 + RANDOM_ITEMS / 3) begin
        send_idle_pct = 69;
        recv_idle_pct = 8;
      end
      send_random_list();
    end
    items_if.valid <= 1'b0;

    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d elements in %0d lists, %0d of them longer than the row.",
             items_sent, lists_sent, overflow_lists);
    $display("Checked %0d sorted results, %0d mismatches.", sb.results_seen, sb.errors);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
